/* hw/rtl/sdd_pkg.sv */
package sdd_pkg;

  localparam int WORD_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int NUM_ROWS  = 8;
  localparam int CFG_IDX_W = 3;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [BYTE_W-1:0]    byte_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  typedef enum logic [1:0] {
    ST_CLEAN  = 2'd0,
    ST_SINGLE = 2'd1,
    ST_DOUBLE = 2'd2,
    ST_UNCORR = 2'd3
  } status_e;

endpackage

/* hw/rtl/sdd_if.sv */
interface sdd_in_if import sdd_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t codeword;

  modport source (output valid, output codeword, input ready);
  modport sink   (input valid, input codeword, output ready);
endinterface

interface sdd_out_if import sdd_pkg::*; ();
  logic    valid;
  logic    ready;
  byte_t   data_byte;
  word_t   fixed_word;
  status_e status;

  modport source (output valid, output data_byte, output fixed_word, output status,
                  input ready);
  modport sink   (input valid, input data_byte, input fixed_word, input status,
                  output ready);
endinterface

interface sdd_cfg_if import sdd_pkg::*; ();
  logic     valid;
  logic     ready;
  cfg_idx_t index;
  word_t    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/syndrome_double_error_decoder_unit.sv */
// Two register stages: input word, then result; the decode sits between them.
// A result becomes valid when its word moves from the input stage into the result stage.
// Throughput: one word per cycle; each stage moves when the one after it is free.
// Reset (rst_ni low, async): all stages empty, parity-check rows cleared to zero.
module syndrome_double_error_decoder_unit import sdd_pkg::*; #(
  parameter int DATA_BITS = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sdd_cfg_if.sink   cfg_i,
  sdd_in_if.sink    in_i,
  sdd_out_if.source out_o
);

  localparam int WB = 2 * DATA_BITS;

  logic [WB-1:0][DATA_BITS-1:0] cols;

  sdd_cfg_regs #(.DATA_BITS(DATA_BITS)) u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cols_o (cols)
  );

  // pipeline control
  logic s1_v_q, out_v_q;
  logic adv_out;

  assign adv_out    = !out_v_q || out_o.ready;
  assign in_i.ready = !s1_v_q || adv_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (in_i.ready) s1_v_q  <= in_i.valid;
      if (adv_out)    out_v_q <= s1_v_q;
    end
  end

  // stage 1: input word
  word_t s1_word_q;

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) s1_word_q <= in_i.codeword;
  end

  // syndrome and column / pair matches
  logic [DATA_BITS-1:0]    syn;
  logic                    syn_nz;
  logic [WB-1:0]           single_match;
  logic [WB-1:0][WB-1:0]   pair_match;

  always_comb begin
    syn = '0;
    for (int p = 0; p < WB; p++) begin
      if (s1_word_q[WORD_W-1-p]) syn = syn ^ cols[p];
    end
    syn_nz = |syn;
    for (int i = 0; i < WB; i++) begin
      single_match[i] = (cols[i] == syn);
      for (int j = 0; j < WB; j++) begin
        pair_match[i][j] = (j > i) && ((cols[i] ^ cols[j]) == syn);
      end
    end
  end

  // pick first pair, else first column, and flip
  word_t   flip_mask, pair_mask, single_mask, fixed_d;
  logic    pair_hit, single_hit;
  status_e status_d;

  always_comb begin
    pair_mask   = '0;
    single_mask = '0;
    pair_hit    = 1'b0;
    single_hit  = 1'b0;
    // walk backwards so the lowest (i, j) wins
    for (int i = WB - 1; i >= 0; i--) begin
      for (int j = WB - 1; j >= 0; j--) begin
        if (pair_match[i][j]) begin
          pair_mask = '0;
          pair_mask[WORD_W-1-i] = 1'b1;
          pair_mask[WORD_W-1-j] = 1'b1;
          pair_hit = 1'b1;
        end
      end
    end
    for (int p = WB - 1; p >= 0; p--) begin
      if (single_match[p]) begin
        single_mask = '0;
        single_mask[WORD_W-1-p] = 1'b1;
        single_hit = 1'b1;
      end
    end

    flip_mask = '0;
    if (!syn_nz) begin
      status_d = ST_CLEAN;
    end else if (pair_hit) begin
      status_d  = ST_DOUBLE;
      flip_mask = pair_mask;
    end else if (single_hit) begin
      status_d  = ST_SINGLE;
      flip_mask = single_mask;
    end else begin
      status_d = ST_UNCORR;
    end
    fixed_d = s1_word_q ^ flip_mask;
  end

  word_t   fixed_q;
  status_e status_q;

  always_ff @(posedge clk_i) begin
    if (adv_out) begin
      fixed_q  <= fixed_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid      = out_v_q;
  assign out_o.fixed_word = fixed_q;
  assign out_o.data_byte  = BYTE_W'(fixed_q[WORD_W-1 -: DATA_BITS]);
  assign out_o.status     = status_q;

endmodule

/* hw/rtl/sdd_cfg_regs.sv */
module sdd_cfg_regs import sdd_pkg::*; #(
  parameter int DATA_BITS = 8
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  sdd_cfg_if.sink                               cfg_i,
  output logic [2*DATA_BITS-1:0][DATA_BITS-1:0] cols_o
);

  localparam int WB = 2 * DATA_BITS;

  word_t rows_q [NUM_ROWS];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_ROWS; k++) begin
        rows_q[k] <= '0;
      end
    end else if (cfg_i.valid && cfg_i.ready) begin
      rows_q[cfg_i.index] <= cfg_i.data;
    end
  end

  // column p, bit k = row k entry at word bit 15-p
  always_comb begin
    for (int p = 0; p < WB; p++) begin
      for (int k = 0; k < DATA_BITS; k++) begin
        cols_o[p][k] = rows_q[k][WORD_W-1-p];
      end
    end
  end

endmodule
